@@ src/vpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vpfc_pkg - shared types and constants of the video pixel format converter
// Geometry limits, format and register codes, the job record passed from
// the classifier to the conversion pipe, and the small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package vpfc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // configuration port
  localparam int CFG_W     = 14;   // widest register (row pitch)
  localparam int CFG_DIM_W = 12;   // width and height registers
  localparam int CFG_FMT_W = 2;

  // internal widths follow from the geometry limits
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int COL_W   = DIM_W + 1;                  // column may overshoot width
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W   = DIM_W + ROW_W;              // linear texel position
  localparam int BPW_W   = $clog2(4 * MAX_WIDTH + 1);  // bytes in a packed row
  localparam int PITCH_W = (BPW_W > CFG_W) ? BPW_W : CFG_W;
  localparam int EXT_W   = (DIM_W > ROW_W ? DIM_W : ROW_W) + CFG_DIM_W;
  localparam int IDX_W   = 22;

  // job queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // BT.601 integer coefficients
  localparam int C_Y   = 298;
  localparam int C_BU  = 516;
  localparam int C_GU  = 100;
  localparam int C_GV  = 208;
  localparam int C_RV  = 409;
  localparam int Y_OFS = 16;
  localparam int UV_OFS = 128;
  localparam int RND   = 128;
  localparam int SUM_W = 20;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_FMT_W-1:0] {
    FMT_RGB24  = 2'd0,
    FMT_RGB32  = 2'd1,
    FMT_ARGB32 = 2'd2,
    FMT_YUY2   = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [POS_W-1:0] wh;
  } geom_t;

  // one conversion job: a BGRA pixel, or a YUY2 group giving two pixels
  typedef struct packed {
    logic             yuv;
    logic [7:0]       b0;    // B  | Y0
    logic [7:0]       b1;    // G  | U
    logic [7:0]       b2;    // R  | Y1
    logic [7:0]       b3;    // A  | V
    logic [POS_W-1:0] base;  // row base (rgb) or texel position (yuv)
    logic [COL_W-1:0] col;
    logic             done;
  } job_t;

  // zero counts as one, saturate at the maximum
  function automatic logic [EXT_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v,
                                               input logic [EXT_W-1:0] maxv);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (v == '0) begin
      eff_dim = EXT_W'(1);
    end else if (ve > maxv) begin
      eff_dim = maxv;
    end else begin
      eff_dim = ve;
    end
  endfunction

  // round, arithmetic shift by eight, clamp to one byte
  function automatic logic [7:0] yuv_clamp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + SUM_W'(RND)) >>> 8;
    if (t < 0) begin
      yuv_clamp = 8'd0;
    end else if (t > 255) begin
      yuv_clamp = 8'hFF;
    end else begin
      yuv_clamp = t[7:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ src/vpfc_queue.sv @@
// ----------------------------------------------------------------------------
// vpfc_queue - job queue between classifier and conversion pipe
// Small first-in first-out store of job records with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module vpfc_queue import vpfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ src/vpfc_front.sv @@
// ----------------------------------------------------------------------------
// vpfc_front - configuration registers, byte classifier and frame position
// Tracks phase, row byte count, column and row per accepted byte, and
// queues a job whenever a pixel or a YUY2 group is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module vpfc_front import vpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_fs,
  input  logic             q_full,
  output logic             in_ready,
  output logic             push,
  output job_t             push_job,
  output geom_t            geom
);

  fmt_t             fmt_r;
  logic [DIM_W-1:0] w_r;
  logic [ROW_W-1:0] h_r;
  logic [CFG_W-1:0] pitch_cfg_r;
  logic             recalc_r;
  logic [POS_W-1:0] wh_r;
  logic [PITCH_W-1:0] pitch_r;

  logic [7:0]         held_r [3];
  logic [7:0]         held_nxt [3];
  logic [1:0]         phase_r, phase_nxt;
  logic [PITCH_W-1:0] rbc_r, rbc_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [POS_W-1:0]   rb_r, rb_nxt;
  logic               fin_r, fin_nxt;
  logic               norm_r, norm_nxt;

  logic               accept;
  logic [1:0]         s_phase;
  logic [PITCH_W-1:0] s_rbc;
  logic [COL_W-1:0]   s_col;
  logic [ROW_W-1:0]   s_row;
  logic [POS_W-1:0]   s_rb;
  logic               s_fin;
  logic [POS_W-1:0]   p;
  logic [POS_W:0]     p1, p2, total;
  logic               nogrp, done_y;
  logic [COL_W:0]     c2, c2w;
  logic               wrap1;
  logic [1:0]         bpp_m1;
  logic               col_in, row_out, emit, done_r;
  logic [ROW_W:0]     row1;
  logic [COL_W:0]     col1;
  logic [PITCH_W:0]   rbc1;
  logic [COL_W-1:0]   ncol;
  logic [PITCH_W-1:0] bpw;

  assign in_ready = !recalc_r && !norm_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign geom.w   = w_r;
  assign geom.wh  = wh_r;

  assign bpw = (fmt_r == FMT_RGB24) ? PITCH_W'({w_r, 1'b0}) + PITCH_W'(w_r)
                                    : PITCH_W'({w_r, 2'b00});

  always_comb begin
    // a frame start clears the position before the byte is looked at
    s_phase = in_fs ? '0 : phase_r;
    s_rbc   = in_fs ? '0 : rbc_r;
    s_col   = in_fs ? '0 : col_r;
    s_row   = in_fs ? '0 : row_r;
    s_rb    = in_fs ? '0 : rb_r;
    s_fin   = in_fs ? 1'b0 : fin_r;

    p      = s_rb + POS_W'(s_col);
    p1     = (POS_W+1)'(p) + 1'b1;
    p2     = (POS_W+1)'(p) + 2'd2;
    total  = (POS_W+1)'({wh_r[POS_W-1:1], 1'b0});
    nogrp  = (p1 >= total);
    done_y = (p2 >= total);
    c2     = (COL_W+1)'(s_col) + 2'd2;
    wrap1  = (c2 >= (COL_W+1)'(w_r));
    c2w    = wrap1 ? c2 - (COL_W+1)'(w_r) : c2;

    bpp_m1  = (fmt_r == FMT_RGB24) ? 2'd2 : 2'd3;
    col_in  = (s_col < COL_W'(w_r));
    row_out = (s_row >= h_r);
    emit    = col_in && (s_phase >= bpp_m1);
    col1    = (COL_W+1)'(s_col) + 1'b1;
    row1    = (ROW_W+1)'(s_row) + 1'b1;
    done_r  = (col1 >= (COL_W+1)'(w_r)) && (row1 >= (ROW_W+1)'(h_r));
    rbc1    = (PITCH_W+1)'(s_rbc) + 1'b1;
    ncol    = col_r - COL_W'(w_r);

    held_nxt  = held_r;
    phase_nxt = phase_r;
    rbc_nxt   = rbc_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rb_nxt    = rb_r;
    fin_nxt   = fin_r;
    norm_nxt  = norm_r;
    push      = 1'b0;
    push_job  = '0;

    if (recalc_r) begin
      // geometry changed: rebuild the row base of the current row
      rb_nxt = POS_W'(row_r) * POS_W'(w_r);
    end else if (accept) begin
      phase_nxt = s_phase;
      rbc_nxt   = s_rbc;
      col_nxt   = s_col;
      row_nxt   = s_row;
      rb_nxt    = s_rb;
      fin_nxt   = s_fin;
      if (!s_fin) begin
        if (fmt_r == FMT_YUY2) begin
          if (nogrp) begin
            fin_nxt = 1'b1;
          end else if (s_phase != 2'd3) begin
            held_nxt[s_phase] = in_byte;
            phase_nxt = s_phase + 1'b1;
          end else begin
            push          = 1'b1;
            push_job.yuv  = 1'b1;
            push_job.b0   = held_r[0];
            push_job.b1   = held_r[1];
            push_job.b2   = held_r[2];
            push_job.b3   = in_byte;
            push_job.base = p;
            push_job.col  = s_col;
            push_job.done = done_y;
            phase_nxt     = '0;
            fin_nxt       = done_y;
            col_nxt       = COL_W'(c2w);
            if (wrap1) begin
              row_nxt  = s_row + 1'b1;
              rb_nxt   = s_rb + POS_W'(w_r);
              norm_nxt = (c2w >= (COL_W+1)'(w_r));
            end
          end
        end else begin
          if (row_out) begin
            fin_nxt = 1'b1;
          end else begin
            if (col_in) begin
              if (!emit) begin
                held_nxt[s_phase] = in_byte;
                phase_nxt = s_phase + 1'b1;
              end else begin
                push          = 1'b1;
                push_job.yuv  = 1'b0;
                push_job.b0   = held_r[0];
                push_job.b1   = held_r[1];
                push_job.b2   = (fmt_r == FMT_RGB24) ? in_byte : held_r[2];
                push_job.b3   = (fmt_r == FMT_ARGB32) ? in_byte : ALPHA_OPAQUE;
                push_job.base = s_rb;
                push_job.col  = s_col;
                push_job.done = done_r;
                phase_nxt     = '0;
                col_nxt       = COL_W'(col1);
                fin_nxt       = done_r;
              end
            end
            if (!(emit && done_r)) begin
              if (rbc1 >= (PITCH_W+1)'(pitch_r)) begin
                rbc_nxt   = '0;
                col_nxt   = '0;
                phase_nxt = '0;
                row_nxt   = ROW_W'(row1);
                rb_nxt    = s_rb + POS_W'(w_r);
                fin_nxt   = (row1 >= (ROW_W+1)'(h_r));
              end else begin
                rbc_nxt = PITCH_W'(rbc1);
              end
            end
          end
        end
      end
    end else if (norm_r) begin
      // column still a row width or more past the row end: one row a cycle while no geometry rebuild is pending
      col_nxt  = ncol;
      row_nxt  = row_r + 1'b1;
      rb_nxt   = rb_r + POS_W'(w_r);
      norm_nxt = (ncol >= COL_W'(w_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RGB24;
      w_r         <= DIM_W'(1);
      h_r         <= ROW_W'(1);
      pitch_cfg_r <= CFG_W'(4);
      wh_r        <= POS_W'(1);
      pitch_r     <= PITCH_W'(4);
      recalc_r    <= 1'b0;
      held_r      <= '{default: '0};
      phase_r     <= '0;
      rbc_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      rb_r        <= '0;
      fin_r       <= 1'b0;
      norm_r      <= 1'b0;
    end else begin
      recalc_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FORMAT: fmt_r <= fmt_t'(cfg_data[CFG_FMT_W-1:0]);
          CFG_WIDTH: begin
            w_r <= DIM_W'(eff_dim(cfg_data[CFG_DIM_W-1:0], EXT_W'(MAX_WIDTH)));
          end
          CFG_HEIGHT: begin
            h_r <= ROW_W'(eff_dim(cfg_data[CFG_DIM_W-1:0], EXT_W'(MAX_HEIGHT)));
          end
          CFG_PITCH: pitch_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      if (recalc_r) begin
        wh_r    <= POS_W'(w_r) * POS_W'(h_r);
        pitch_r <= (PITCH_W'(pitch_cfg_r) > bpw) ? PITCH_W'(pitch_cfg_r) : bpw;
      end
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      rbc_r   <= rbc_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rb_r    <= rb_nxt;
      fin_r   <= fin_nxt;
      norm_r  <= norm_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/vpfc_back.sv @@
// ----------------------------------------------------------------------------
// vpfc_back - texel conversion pipe
// Takes jobs from the queue, forms the texel index, runs the BT.601
// products and the rounding clamp, and holds the result in the output
// register. A YUY2 job issues twice, one texel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module vpfc_back import vpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  job_t             head,
  input  logic             q_empty,
  input  geom_t            geom,
  input  logic             out_ready,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       blue,
  output logic [7:0]       green,
  output logic [7:0]       red,
  output logic [7:0]       alpha,
  output logic [IDX_W-1:0] texel_index,
  output logic             run_last,
  output logic             frame_done
);

  logic adv, issue, half_r;
  logic [7:0] y_sel;
  logic signed [9:0] ty;
  logic signed [8:0] tu, tv;
  logic [IDX_W-1:0]  idx_c;

  // product stage
  logic                    va_r, yuv_a_r, last_a_r, done_a_r;
  logic [7:0]              b0_a_r, b1_a_r, b2_a_r, b3_a_r;
  logic [IDX_W-1:0]        idx_a_r;
  logic signed [SUM_W-1:0] py_a_r, pbu_a_r, pgu_a_r, pgv_a_r, prv_a_r;
  logic signed [SUM_W-1:0] sb, sg, sr;

  // output register
  logic             ov_r, last_r, done_r;
  logic [7:0]       blue_r, green_r, red_r, alpha_r;
  logic [IDX_W-1:0] idx_r;

  assign adv   = !ov_r || out_ready;
  assign issue = !q_empty && adv;
  assign pop   = issue && (!head.yuv || half_r);

  always_comb begin
    y_sel = half_r ? head.b2 : head.b0;
    ty    = 10'($signed({2'b00, y_sel}) - 10'(Y_OFS));
    tu    = 9'($signed({1'b0, head.b1}) - 9'(UV_OFS));
    tv    = 9'($signed({1'b0, head.b3}) - 9'(UV_OFS));
    if (head.yuv) begin
      idx_c = IDX_W'(head.base + POS_W'(half_r));
    end else begin
      idx_c = IDX_W'(geom.wh - POS_W'(geom.w) - head.base + POS_W'(head.col));
    end
    sb = py_a_r + pbu_a_r;
    sg = py_a_r - pgu_a_r - pgv_a_r;
    sr = py_a_r + prv_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      va_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (issue && head.yuv) begin
        half_r <= !half_r;
      end
      if (adv) begin
        va_r <= issue;
        ov_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yuv_a_r  <= head.yuv;
      last_a_r <= !head.yuv || half_r;
      done_a_r <= head.done && (!head.yuv || half_r);
      b0_a_r   <= head.b0;
      b1_a_r   <= head.b1;
      b2_a_r   <= head.b2;
      b3_a_r   <= head.b3;
      idx_a_r  <= idx_c;
      py_a_r   <= SUM_W'(ty * C_Y);
      pbu_a_r  <= SUM_W'(tu * C_BU);
      pgu_a_r  <= SUM_W'(tu * C_GU);
      pgv_a_r  <= SUM_W'(tv * C_GV);
      prv_a_r  <= SUM_W'(tv * C_RV);

      if (yuv_a_r) begin
        blue_r  <= yuv_clamp(sb);
        green_r <= yuv_clamp(sg);
        red_r   <= yuv_clamp(sr);
        alpha_r <= ALPHA_OPAQUE;
      end else begin
        blue_r  <= b0_a_r;
        green_r <= b1_a_r;
        red_r   <= b2_a_r;
        alpha_r <= b3_a_r;
      end
      idx_r  <= idx_a_r;
      last_r <= last_a_r;
      done_r <= done_a_r;
    end
  end

  assign out_valid   = ov_r;
  assign blue        = blue_r;
  assign green       = green_r;
  assign red         = red_r;
  assign alpha       = alpha_r;
  assign texel_index = idx_r;
  assign run_last    = last_r;
  assign frame_done  = done_r;

endmodule

`default_nettype wire

@@ src/video_pixel_format_converter_top.sv @@
// ----------------------------------------------------------------------------
// video_pixel_format_converter_top - raw video bytes to BGRA texels
// Byte-stream in, texel stream out, with a plain register write port.
// ----------------------------------------------------------------------------
// The block takes one raw frame byte per beat and one cycle, and gives
// BGRA texels with their index in the destination texture. RGB24, RGB32
// and ARGB32 pixels are gathered from 3 or 4 bytes, padding up to the row
// pitch is dropped, and rows are flipped (the source is bottom-up); one
// texel leaves for every 3 or 4 bytes. A YUY2 group of four bytes gives
// two texels through BT.601 integer coefficients, leaving one after the
// other, rows kept top-down. The input side runs at one byte per clock
// when not stalled, set by the position update in the classifier;
// the conversion pipe behind the four-entry job queue emits one texel a
// cycle, so the queue never fills at full input rate while the sink keeps
// up; under sink back-pressure in_tready drops while the queue is full.
// in_tready also drops for one cycle after every configuration write while
// the geometry products (width times height, row base, effective pitch)
// are rebuilt, and, in YUY2 only, while the column is walked back a row
// at a time whenever a group leaves it a whole row width or more past the
// row end: on every group at a width of one, and when a narrower width
// takes effect in mid-frame. The completing byte's job passes through the
// job queue, the product stage and the output register; a YUY2 group's
// second texel follows its first. Bytes after the frame's last texel are
// dropped until a beat with in_tuser set starts the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module video_pixel_format_converter_top import vpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // byte stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] byte_in
  input  logic             in_tuser,   // [0] frame_start
  // texel stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,  // [7:0] blue, [15:8] green, [23:16] red,
                                       // [31:24] alpha, [53:32] texel_index
  output logic             out_tlast,  // run_last
  output logic             out_tuser   // [0] frame_done
);

  logic  push, pop, q_empty, q_full;
  job_t  push_job, head;
  geom_t geom;

  logic [7:0]       blue, green, red, alpha;
  logic [IDX_W-1:0] texel_index;

  // classify bytes and track the frame position
  vpfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_fs     (in_tuser),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .push      (push),
    .push_job  (push_job),
    .geom      (geom)
  );

  // decouple classifier and conversion pipe
  vpfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // convert and hold the texel until the sink takes it
  vpfc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .geom        (geom),
    .out_ready   (out_tready),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .alpha       (alpha),
    .texel_index (texel_index),
    .run_last    (out_tlast),
    .frame_done  (out_tuser)
  );

  assign out_tdata = {2'b00, texel_index, alpha, red, green, blue};

  // never queue a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // hold off bytes while geometry is rebuilt
  a_recalc_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("byte accepted during geometry rebuild");

  // the frame's final texel closes its byte's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame_done without run_last");

  // pop only what is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
